FILE: design/cdm_pkg.sv
// ----------------------------------------------------------------------------
// Curvature drive mixer package
// Shared types, constants and helper functions for the drive mixer.
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int SINE_STEPS = 16;
  localparam int ATAN_N = 24;
  localparam int CORDIC_W = 34;
  localparam int CORDIC_IDX_W = 5;
  localparam int ANG_W = 18;
  localparam int MUL_A_W = 36;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = 53;
  localparam int MUL_CNT_W = 5;

  localparam logic signed [ANG_W-1:0] Q_PI = 18'sd51472;
  localparam logic signed [ANG_W-1:0] Q_HALF_PI = 18'sd25736;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INERTIA_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ANGLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_NORM = 3'd5;

  typedef struct packed {
    logic signed [15:0] throttle;
    logic signed [15:0] turn;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_power;
    logic signed [15:0] right_power;
    logic in_place;
  } out_word_t;

  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [CORDIC_IDX_W-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      5'd0: v = 34'sd843314857;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043837;
      5'd3: v = 34'sd133525159;
      5'd4: v = 34'sd67021687;
      5'd5: v = 34'sd33543516;
      5'd6: v = 34'sd16775851;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194283;
      5'd9: v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [MUL_P_W-1:0] round_shift(input logic signed [MUL_P_W-1:0] v,
                                                           input int s);
    logic signed [MUL_P_W-1:0] half;
    half = MUL_P_W'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [MUL_P_W-1:0] v);
    logic signed [15:0] r;
    if (v > MUL_P_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -MUL_P_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [MUL_P_W-1:0] v);
    logic signed [17:0] r;
    if (v > MUL_P_W'(131071)) begin
      r = 18'sh1ffff;
    end else if (v < -MUL_P_W'(131072)) begin
      r = 18'sh20000;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

endpackage

FILE: design/cdm_mul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Signed by unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cdm_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [cdm_pkg::MUL_A_W-1:0] a,
  input  logic [cdm_pkg::MUL_B_W-1:0] b,
  output logic done,
  output logic signed [cdm_pkg::MUL_P_W-1:0] p
);
  import cdm_pkg::*;

  logic signed [MUL_P_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [MUL_CNT_W-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh <= MUL_P_W'(a);
        b_sh <= b;
        p <= '0;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b_sh[0]) begin
          p <= p + a_sh;
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/cdm_cordic.sv
// ----------------------------------------------------------------------------
// Iterative sine unit
// Rotation-mode CORDIC, one micro-rotation per cycle, Q4.14 in and out.
// ----------------------------------------------------------------------------
module cdm_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [cdm_pkg::ANG_W-1:0] angle,
  output logic done,
  output logic signed [cdm_pkg::ANG_W-1:0] sine
);
  import cdm_pkg::*;

  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic signed [CORDIC_W-1:0] z;
  logic [CORDIC_IDX_W-1:0] idx;
  logic busy;
  logic signed [ANG_W-1:0] folded;
  logic signed [CORDIC_W-1:0] x_sh;
  logic signed [CORDIC_W-1:0] y_sh;
  logic signed [CORDIC_W-1:0] y_rnd;

  always_comb begin
    if (angle > Q_HALF_PI) begin
      folded = Q_PI - angle;
    end else if (angle < -Q_HALF_PI) begin
      folded = -Q_PI - angle;
    end else begin
      folded = angle;
    end
    x_sh = x >>> idx;
    y_sh = y >>> idx;
    y_rnd = (y + CORDIC_W'(32768)) >>> 16;
  end

  assign sine = y_rnd[ANG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x <= CORDIC_GAIN;
        y <= '0;
        z <= {folded, 16'b0};
        idx <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[CORDIC_W-1]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_q30(idx);
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_q30(idx);
        end
        idx <= idx + 1'b1;
        if (idx == CORDIC_IDX_W'(SINE_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/curvature_drive_mixer_top.sv
// ----------------------------------------------------------------------------
// Curvature drive mixer
// Throttle and turn in, left and right wheel power out, all in Q2.14.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Word
//  in       in_valid / in_stall  in_data  (throttle, turn)
//  out      out_valid / out_stall out_data (left_power, right_power, in_place)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A word runs two remap passes, each an angle multiply, a CORDIC pass and a norm
// multiply; then come one further multiply for a turn in place or three while
// driving, the load of the output register and the return to idle. A new word
// is taken only in idle, so the block does not accept the next word until the
// last has been loaded. All multiplies share the one serial multiplier.
// Reset is synchronous and restores the register defaults and clears state.
// A result waits in the output register while the next word is computed, and
// a stalled output holds the block in its last state until the word is taken.
module curvature_drive_mixer_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  cdm_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output cdm_pkg::out_word_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [cdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import cdm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ANG1 = 12'b000000000010,
    S_SIN1 = 12'b000000000100,
    S_NRM1 = 12'b000000001000,
    S_ANG2 = 12'b000000010000,
    S_SIN2 = 12'b000000100000,
    S_NRM2 = 12'b000001000000,
    S_SQR  = 12'b000010000000,
    S_DIF  = 12'b000100000000,
    S_PRD1 = 12'b001000000000,
    S_PRD2 = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_prev;
  logic kick;

  logic [14:0] deadband;
  logic [14:0] slew_step;
  logic [14:0] inertia_gain;
  logic [14:0] turn_gain;
  logic [14:0] remap_angle;
  logic [15:0] remap_norm;

  logic signed [15:0] last_turn;
  logic signed [15:0] last_throttle;
  logic signed [17:0] acc;
  logic signed [15:0] thr;
  logic signed [15:0] trn;
  logic signed [15:0] lin;
  logic in_place;
  logic signed [ANG_W-1:0] ang;
  logic signed [ANG_W-1:0] sine_r;
  logic signed [15:0] v;
  logic signed [MUL_A_W-1:0] q;
  logic signed [15:0] left_r;
  logic signed [15:0] right_r;

  logic mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic mul_done;
  logic signed [MUL_P_W-1:0] mul_p;
  logic cor_start;
  logic cor_done;
  logic signed [ANG_W-1:0] cor_sine;

  logic accept;
  logic out_free;
  logic signed [16:0] thr_mag;
  logic signed [16:0] trn_mag;
  logic signed [17:0] thr_diff;
  logic signed [17:0] slew1;
  logic signed [17:0] slew2;
  logic in_place_next;
  logic signed [17:0] lin_next;
  logic [MUL_B_W-1:0] v_mag;
  logic [MUL_B_W-1:0] lin_mag;
  logic signed [MUL_P_W-1:0] rnd12;
  logic signed [MUL_P_W-1:0] rnd14;
  logic signed [MUL_P_W-1:0] rnd26;
  logic signed [MUL_P_W-1:0] lin_ext;

  cdm_mul u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a),
    .b(mul_b),
    .done(mul_done),
    .p(mul_p)
  );

  cdm_cordic u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cor_start),
    .angle(ang),
    .done(cor_done),
    .sine(cor_sine)
  );

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign kick = (state != state_prev);

  always_comb begin
    thr_mag = in_data.throttle[15] ? -17'(in_data.throttle) : 17'(in_data.throttle);
    trn_mag = in_data.turn[15] ? -17'(in_data.turn) : 17'(in_data.turn);
    thr_diff = 18'(in_data.throttle) - 18'(last_throttle);
    slew1 = $signed({3'b0, slew_step});
    slew2 = $signed({2'b0, slew_step, 1'b0});
    in_place_next = (thr_mag < $signed({2'b0, deadband}))
                    && (trn_mag > $signed({2'b0, deadband}));
    if (in_place_next) begin
      lin_next = '0;
    end else if (thr_diff > slew1) begin
      lin_next = 18'(last_throttle) + slew1;
    end else if (thr_diff < -slew2) begin
      lin_next = 18'(last_throttle) - slew2;
    end else begin
      lin_next = 18'(in_data.throttle);
    end
    v_mag = v[15] ? MUL_B_W'(-17'(v)) : MUL_B_W'(v);
    lin_mag = lin[15] ? MUL_B_W'(-17'(lin)) : MUL_B_W'(lin);
    rnd12 = round_shift(mul_p, 12);
    rnd14 = round_shift(mul_p, 14);
    rnd26 = round_shift(mul_p, 26);
    lin_ext = MUL_P_W'(lin);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_ANG1: begin
        mul_a = MUL_A_W'(trn);
        mul_b = MUL_B_W'(remap_angle);
      end
      S_ANG2: begin
        mul_a = MUL_A_W'(v);
        mul_b = MUL_B_W'(remap_angle);
      end
      S_NRM1, S_NRM2: begin
        mul_a = MUL_A_W'(sine_r);
        mul_b = MUL_B_W'(remap_norm);
      end
      S_SQR: begin
        mul_a = MUL_A_W'(v);
        mul_b = v_mag;
      end
      S_DIF: begin
        mul_a = MUL_A_W'(17'(trn) - 17'(last_turn));
        mul_b = MUL_B_W'(inertia_gain);
      end
      S_PRD1: begin
        mul_a = MUL_A_W'(19'(v) + 19'(acc));
        mul_b = lin_mag;
      end
      S_PRD2: begin
        mul_a = q;
        mul_b = MUL_B_W'(turn_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_start = kick && (state == S_ANG1 || state == S_ANG2 || state == S_NRM1
                         || state == S_NRM2 || state == S_SQR || state == S_DIF
                         || state == S_PRD1 || state == S_PRD2);
    cor_start = kick && (state == S_SIN1 || state == S_SIN2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= 15'd328;
      slew_step <= 15'd328;
      inertia_gain <= 15'd12288;
      turn_gain <= 15'd4096;
      remap_angle <= 15'd12868;
      remap_norm <= 16'd23170;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADBAND: deadband <= cfg_data[14:0];
        CFG_SLEW_STEP: slew_step <= cfg_data[14:0];
        CFG_INERTIA_GAIN: inertia_gain <= cfg_data[14:0];
        CFG_TURN_GAIN: turn_gain <= cfg_data[14:0];
        CFG_REMAP_ANGLE: remap_angle <= cfg_data[14:0];
        CFG_REMAP_NORM: remap_norm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      state_prev <= S_IDLE;
      out_valid <= 1'b0;
      last_turn <= '0;
      last_throttle <= '0;
      acc <= '0;
    end else begin
      state_prev <= state;
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            thr <= in_data.throttle;
            trn <= in_data.turn;
            lin <= lin_next[15:0];
            in_place <= in_place_next;
            state <= S_ANG1;
          end
        end
        S_ANG1, S_ANG2: begin
          if (mul_done) begin
            ang <= rnd14[ANG_W-1:0];
            state <= (state == S_ANG1) ? S_SIN1 : S_SIN2;
          end
        end
        S_SIN1, S_SIN2: begin
          if (cor_done) begin
            sine_r <= cor_sine;
            state <= (state == S_SIN1) ? S_NRM1 : S_NRM2;
          end
        end
        S_NRM1: begin
          if (mul_done) begin
            v <= sat16(rnd14);
            state <= S_ANG2;
          end
        end
        S_NRM2: begin
          if (mul_done) begin
            v <= sat16(rnd14);
            state <= in_place ? S_SQR : S_DIF;
          end
        end
        S_SQR: begin
          if (mul_done) begin
            left_r <= sat16(rnd14);
            right_r <= sat16(-rnd14);
            state <= S_OUT;
          end
        end
        S_DIF: begin
          if (mul_done) begin
            acc <= sat18(MUL_P_W'(acc) + rnd12);
            state <= S_PRD1;
          end
        end
        S_PRD1: begin
          if (mul_done) begin
            q <= mul_p[MUL_A_W-1:0];
            state <= S_PRD2;
          end
        end
        S_PRD2: begin
          if (mul_done) begin
            left_r <= sat16(lin_ext + rnd26);
            right_r <= sat16(lin_ext - rnd26);
            if (acc > ONE_Q14) begin
              acc <= acc - ONE_Q14;
            end else if (acc < -ONE_Q14) begin
              acc <= acc + ONE_Q14;
            end else begin
              acc <= '0;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data.left_power <= left_r;
            out_data.right_power <= right_r;
            out_data.in_place <= in_place;
            out_valid <= 1'b1;
            last_turn <= trn;
            last_throttle <= thr;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Curvature drive mixer testbench
// Drives throttle and turn words through the mixer with random gaps on both
// sides and checks every result word against a bit-exact model of the mixer.
// ----------------------------------------------------------------------------
module tb;
  import cdm_pkg::*;

  typedef struct {
    logic signed [15:0] thr;
    logic signed [15:0] trn;
    logic chk;
    out_word_t res;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_data;
  logic out_valid;
  logic out_stall;
  out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  curvature_drive_mixer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint deadband_r, slew_r, igain_r, tgain_r, angle_r, norm_r;
  longint prev_turn, prev_thr, inertia;
  out_word_t power_q[$];
  int errors;
  int cycles;
  bit hold_off;
  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint half_up(longint v, int s);
    return floor_shift(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sine_q14(longint a);
    longint x, y, z, nx;
    x = 652032874;
    y = 0;
    if (a > 25736) a = 51472 - a;
    else if (a < -25736) a = -51472 - a;
    z = a * 65536;
    for (int i = 0; i < SINE_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    return half_up(y, 16);
  endfunction

  function automatic longint sine_remap(longint v);
    longint s;
    s = sine_q14(half_up(angle_r * v, 14));
    return clamp(half_up(s * norm_r, 14), -32768, 32767);
  endfunction

  function automatic out_word_t mix_word(logic signed [15:0] thr_in,
                                         logic signed [15:0] trn_in);
    longint thr, trn, lin, r, lft, rgt, p, d, ang;
    bit spin;
    out_word_t o;
    thr = thr_in;
    trn = trn_in;
    lin = thr;
    spin = 0;
    if (absval(thr) < deadband_r && absval(trn) > deadband_r) begin
      lin = 0;
      spin = 1;
    end else if (thr - prev_thr > slew_r) begin
      lin = prev_thr + slew_r;
    end else if (thr - prev_thr < -2 * slew_r) begin
      lin = prev_thr - 2 * slew_r;
    end
    r = sine_remap(sine_remap(trn));
    if (spin) begin
      p = half_up(r * absval(r), 14);
      lft = p;
      rgt = -p;
    end else begin
      d = half_up((trn - prev_turn) * igain_r, 12);
      inertia = clamp(inertia + d, -131072, 131071);
      ang = half_up(absval(lin) * (r + inertia) * tgain_r, 26);
      lft = lin + ang;
      rgt = lin - ang;
      if (inertia > 16384) inertia -= 16384;
      else if (inertia < -16384) inertia += 16384;
      else inertia = 0;
    end
    prev_turn = trn;
    prev_thr = thr;
    o.left_power = 16'(clamp(lft, -32768, 32767));
    o.right_power = 16'(clamp(rgt, -32768, 32767));
    o.in_place = spin;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(logic signed [15:0] thr, logic signed [15:0] trn,
                           bit chk, out_word_t want);
    out_word_t pred;
    pred = mix_word(thr, trn);
    if (chk && pred !== want) begin
      report_mismatch("table row vs model", pred, want);
    end
    power_q.push_back(pred);
    in_valid <= 1'b1;
    in_data <= '{throttle: thr, turn: trn};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_DEADBAND: deadband_r = val & 16'h7fff;
      CFG_SLEW_STEP: slew_r = val & 16'h7fff;
      CFG_INERTIA_GAIN: igain_r = val & 16'h7fff;
      CFG_TURN_GAIN: tgain_r = val & 16'h7fff;
      CFG_REMAP_ANGLE: angle_r = val & 16'h7fff;
      CFG_REMAP_NORM: norm_r = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic signed [15:0] thr, trn;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          thr = 16'($urandom());
          trn = 16'($urandom());
        end
        1: begin
          thr = 16'($urandom_range(0, 600) - 300);
          trn = 16'($urandom_range(0, 32768) - 16384);
        end
        2: begin
          thr = 16'(prev_thr + $urandom_range(0, 1200) - 600);
          trn = 16'(prev_turn + $urandom_range(0, 4000) - 2000);
        end
        default: begin
          thr = 16'($urandom_range(0, 32768) - 16384);
          trn = 16'($urandom_range(0, 32768) - 16384);
        end
      endcase
      send_word(thr, trn, 0, '0);
      idle_gap();
    end
  endtask

  row_t rows[$] = '{
    '{16'sd0, 16'sd0, 1, '{16'sd0, 16'sd0, 1'b0}},
    '{16'sd0, 16'sd16384, 0, '0},
    '{16'sd0, -16'sd16384, 0, '0},
    '{16'sd327, 16'sd329, 0, '0},
    '{16'sd327, 16'sd328, 0, '0},
    '{16'sd328, 16'sd2000, 0, '0},
    '{16'sd16384, 16'sd0, 0, '0},
    '{16'sd16384, 16'sd0, 0, '0},
    '{-16'sd16384, 16'sd0, 0, '0},
    '{-16'sd16384, 16'sd16384, 0, '0},
    '{16'sd32767, -16'sd32768, 0, '0},
    '{-16'sd32768, 16'sd32767, 0, '0},
    '{16'sd32767, 16'sd32767, 0, '0},
    '{-16'sd1, -16'sd1, 0, '0},
    '{16'sd8000, 16'sd16384, 0, '0},
    '{16'sd8000, -16'sd16384, 0, '0},
    '{16'sd8000, 16'sd16384, 0, '0},
    '{16'sd0, 16'sd0, 0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("** curvature_drive_mixer_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (power_q.size() == 0) begin
        report_mismatch("unexpected word", out_data, 0);
      end else begin
        out_word_t want;
        want = power_q.pop_front();
        if (out_data.left_power !== want.left_power)
          report_mismatch("left_power", out_data.left_power, want.left_power);
        if (out_data.right_power !== want.right_power)
          report_mismatch("right_power", out_data.right_power, want.right_power);
        if (out_data.in_place !== want.in_place)
          report_mismatch("in_place", out_data.in_place, want.in_place);
      end
    end
  end

  initial begin
    out_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 19) == 0) || ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin
    hold_off = 0;
    @(negedge rst);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (2000) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEADBAND;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    deadband_r = 328; slew_r = 328; igain_r = 12288;
    tgain_r = 4096; angle_r = 12868; norm_r = 23170;
    prev_turn = 0; prev_thr = 0; inertia = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_word(rows[i].thr, rows[i].trn, rows[i].chk, rows[i].res);
      idle_gap();
    end
    random_phase(500);
    drain();
    write_reg(CFG_DEADBAND, 16'd0);
    write_reg(CFG_SLEW_STEP, 16'd16384);
    write_reg(CFG_INERTIA_GAIN, 16'd32767);
    write_reg(CFG_TURN_GAIN, 16'd32767);
    write_reg(CFG_REMAP_ANGLE, 16'd25736);
    write_reg(CFG_REMAP_NORM, 16'd65535);
    random_phase(400);
    drain();
    write_reg(CFG_DEADBAND, 16'd16384);
    write_reg(CFG_SLEW_STEP, 16'd0);
    write_reg(CFG_INERTIA_GAIN, 16'd0);
    write_reg(CFG_TURN_GAIN, 16'd0);
    write_reg(CFG_REMAP_ANGLE, 16'd0);
    write_reg(CFG_REMAP_NORM, 16'd0);
    random_phase(300);
    drain();
    write_reg(CFG_DEADBAND, 16'hffff);
    write_reg(CFG_SLEW_STEP, 16'hffff);
    write_reg(CFG_INERTIA_GAIN, 16'hffff);
    write_reg(CFG_TURN_GAIN, 16'hffff);
    write_reg(CFG_REMAP_ANGLE, 16'hffff);
    write_reg(CFG_REMAP_NORM, 16'd20000);
    random_phase(300);
    drain();
    for (int k = 0; k < 6; k++) begin
      write_reg(CFG_IDX_W'(k), 16'($urandom()));
    end
    write_reg(CFG_DEADBAND, 16'($urandom_range(0, 2000)));
    random_phase(400);
    drain();
    if (errors == 0) begin
      $display("** curvature_drive_mixer_top: PASSED **");
    end else begin
      $display("** curvature_drive_mixer_top: FAILED **");
    end
    $finish;
  end

endmodule
